FILE: hdl/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg: shared types and codes of the first-step path finder
// Beat payloads, mode and status codes, the sequencer states and the control
// structs that pass between the top level and the search core.
// ----------------------------------------------------------------------------
package bfs_pkg;

    // Fixed field widths of the item formats.
    localparam int ROOM_FIELD_W   = 10;
    localparam int FIELD_ROOMS    = 1 << ROOM_FIELD_W;
    localparam int EXIT_W         = ROOM_FIELD_W + 1;
    localparam logic [ROOM_FIELD_W-1:0] TOP_ROOM_RESET = 10'd1023;

    // Item modes.
    localparam logic [1:0] MODE_EXIT  = 2'd0;
    localparam logic [1:0] MODE_FLAG  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Result status codes.
    localparam logic [2:0] STATUS_WRITE  = 3'd0;
    localparam logic [2:0] STATUS_FOUND  = 3'd1;
    localparam logic [2:0] STATUS_THERE  = 3'd2;
    localparam logic [2:0] STATUS_NOPATH = 3'd3;
    localparam logic [2:0] STATUS_ERROR  = 3'd4;

    // Input beat payload.
    typedef struct packed {
        logic [1:0]              mode;
        logic [ROOM_FIELD_W-1:0] room;
        logic [2:0]              direction;
        logic                    exit_present;
        logic [ROOM_FIELD_W-1:0] exit_target;
        logic                    no_track;
        logic [ROOM_FIELD_W-1:0] goal_room;
    } in_item_t;

    // Output beat payload.
    typedef struct packed {
        logic [2:0] status;
        logic [2:0] first_direction;
    } out_item_t;

    // Search core sequencer states.
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_POP,
        S_CLEAR,
        S_EMIT
    } state_t;

    // Control from the top level to the core.
    typedef struct packed {
        logic start;
        logic res_take;
    } core_req_t;

    // Status from the core to the top level.
    typedef struct packed {
        logic idle;
        logic res_vld;
    } core_rsp_t;

endpackage

FILE: hdl/bfs_core.sv
// ----------------------------------------------------------------------------
// bfs_core: memory-based breadth-first search engine
// Holds the exit table, the no-track flags, the visit marks and the search
// queue in synchronous memories. A three-stage edge pipeline reads an exit,
// then the flags of its target, then marks and enqueues the target.
// ----------------------------------------------------------------------------
module bfs_core
    import bfs_pkg::*;
#(
    parameter int MAX_ROOMS = 1024,
    parameter int NUM_DIRS  = 6
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  in_item_t                item,
    input  logic [ROOM_FIELD_W-1:0] top_room,
    input  core_req_t               req,
    output core_rsp_t               rsp,
    output out_item_t               result
);

    localparam int ROOMS      = (MAX_ROOMS < FIELD_ROOMS) ? MAX_ROOMS : FIELD_ROOMS;
    localparam int ROOM_W     = $clog2(ROOMS);
    localparam int DIR_W      = (NUM_DIRS > 1) ? $clog2(NUM_DIRS) : 1;
    localparam int EXIT_DEPTH = ROOMS * NUM_DIRS;
    localparam int EXIT_AW    = $clog2(EXIT_DEPTH);
    localparam int QUEUE_W    = ROOM_W + DIR_W;

    // Memories.
    logic [EXIT_W-1:0]  exit_mem  [EXIT_DEPTH];
    logic               nt_mem    [ROOMS];
    logic               vis_mem   [ROOMS];
    logic [QUEUE_W-1:0] queue_mem [ROOMS];

    // Memory ports.
    logic               exit_we;
    logic [EXIT_AW-1:0] exit_waddr;
    logic [EXIT_W-1:0]  exit_wdata;
    logic [EXIT_AW-1:0] exit_raddr;
    logic [EXIT_W-1:0]  exit_rdata_reg;
    logic               nt_we;
    logic [ROOM_W-1:0]  nt_waddr;
    logic               nt_wdata;
    logic               vis_we;
    logic [ROOM_W-1:0]  vis_waddr;
    logic               vis_wdata;
    logic [ROOM_W-1:0]  flag_raddr;
    logic               nt_rdata_reg;
    logic               vis_rdata_reg;
    logic               q_we;
    logic [ROOM_W-1:0]  q_waddr;
    logic [QUEUE_W-1:0] q_wdata;
    logic [QUEUE_W-1:0] q_rdata_reg;

    // Sequencer and pipeline registers.
    state_t                  state_reg, state_next;
    logic [EXIT_AW-1:0]      cnt_reg, cnt_next;
    logic [DIR_W-1:0]        dir_reg, dir_next;
    logic [EXIT_AW-1:0]      base_reg, base_next;
    logic [DIR_W-1:0]        first_reg, first_next;
    logic                    src_mode_reg, src_mode_next;
    logic [ROOM_FIELD_W-1:0] goal_reg, goal_next;
    logic [ROOM_W-1:0]       head_reg, head_next;
    logic [ROOM_W-1:0]       tail_reg, tail_next;
    logic                    a_vld_reg, a_vld_next;
    logic [DIR_W-1:0]        a_first_reg, a_first_next;
    logic                    b_vld_reg, b_vld_next;
    logic [ROOM_FIELD_W-1:0] b_to_reg, b_to_next;
    logic [DIR_W-1:0]        b_first_reg, b_first_next;
    logic                    mark_vld_reg, mark_vld_next;
    logic [ROOM_W-1:0]       mark_room_reg, mark_room_next;
    out_item_t               res_reg, res_next;

    // Decoded helpers.
    logic                    src_ok;
    logic                    goal_ok;
    logic                    room_ok;
    logic                    dir_ok;
    logic [ROOM_FIELD_W-1:0] a_to;
    logic                    a_ok;
    logic                    b_fwd;
    logic                    b_take;
    logic [ROOM_W-1:0]       q_room;
    logic [DIR_W-1:0]        q_dir;

    assign src_ok  = (item.room <= top_room) && (32'(item.room) < ROOMS);
    assign goal_ok = (item.goal_room <= top_room) && (32'(item.goal_room) < ROOMS);
    assign room_ok = 32'(item.room) < ROOMS;
    assign dir_ok  = 32'(item.direction) < NUM_DIRS;

    // Exit stage: the registered exit entry and its target check.
    assign a_to = exit_rdata_reg[ROOM_FIELD_W-1:0];
    assign a_ok = exit_rdata_reg[EXIT_W-1] && (a_to <= top_room) && (32'(a_to) < ROOMS);

    // Flag stage: the target is taken unless no-track or marked. A mark written
    // in the previous cycle is not yet in the read data, so it is forwarded.
    assign b_fwd  = mark_vld_reg && (mark_room_reg == b_to_reg[ROOM_W-1:0]);
    assign b_take = b_vld_reg && !nt_rdata_reg && !vis_rdata_reg && !b_fwd;

    assign q_room = q_rdata_reg[QUEUE_W-1:DIR_W];
    assign q_dir  = q_rdata_reg[DIR_W-1:0];

    // Exit table memory.
    always_ff @(posedge clk)
    begin
        if (exit_we)
        begin
            exit_mem[exit_waddr] <= exit_wdata;
        end
        exit_rdata_reg <= exit_mem[exit_raddr];
    end

    // No-track flag memory.
    always_ff @(posedge clk)
    begin
        if (nt_we)
        begin
            nt_mem[nt_waddr] <= nt_wdata;
        end
        nt_rdata_reg <= nt_mem[flag_raddr];
    end

    // Visit mark memory.
    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_rdata_reg <= vis_mem[flag_raddr];
    end

    // Search queue memory.
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        q_rdata_reg <= queue_mem[head_reg];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cnt_reg      <= '0;
            dir_reg      <= '0;
            src_mode_reg <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            mark_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            dir_reg      <= dir_next;
            src_mode_reg <= src_mode_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            a_vld_reg    <= a_vld_next;
            b_vld_reg    <= b_vld_next;
            mark_vld_reg <= mark_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        first_reg     <= first_next;
        goal_reg      <= goal_next;
        a_first_reg   <= a_first_next;
        b_to_reg      <= b_to_next;
        b_first_reg   <= b_first_next;
        mark_room_reg <= mark_room_next;
        res_reg       <= res_next;
    end

    // Sequencer and edge pipeline.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dir_next       = dir_reg;
        base_next      = base_reg;
        first_next     = first_reg;
        src_mode_next  = src_mode_reg;
        goal_next      = goal_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        a_vld_next     = 1'b0;
        a_first_next   = a_first_reg;
        res_next       = res_reg;
        rsp.idle       = 1'b0;
        rsp.res_vld    = 1'b0;

        exit_we    = 1'b0;
        exit_waddr = EXIT_AW'(32'(item.room[ROOM_W-1:0]) * NUM_DIRS + 32'(item.direction));
        exit_wdata = item.exit_present ? {1'b1, item.exit_target} : '0;
        exit_raddr = base_reg + EXIT_AW'(dir_reg);
        nt_we      = 1'b0;
        nt_waddr   = item.room[ROOM_W-1:0];
        nt_wdata   = item.no_track;
        vis_we     = 1'b0;
        vis_waddr  = item.room[ROOM_W-1:0];
        vis_wdata  = 1'b1;
        flag_raddr = a_to[ROOM_W-1:0];
        q_we       = 1'b0;
        q_waddr    = tail_reg;
        q_wdata    = {b_to_reg[ROOM_W-1:0], b_first_reg};

        case (state_reg)
            S_INIT:
            begin
                // Clear all exits, flags and marks after reset.
                exit_we    = 1'b1;
                exit_waddr = cnt_reg;
                exit_wdata = '0;
                if (32'(cnt_reg) < ROOMS)
                begin
                    nt_we     = 1'b1;
                    nt_waddr  = cnt_reg[ROOM_W-1:0];
                    nt_wdata  = 1'b0;
                    vis_we    = 1'b1;
                    vis_waddr = cnt_reg[ROOM_W-1:0];
                    vis_wdata = 1'b0;
                end
                if (cnt_reg == EXIT_AW'(EXIT_DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                rsp.idle = 1'b1;
                if (req.start)
                begin
                    res_next.status          = STATUS_WRITE;
                    res_next.first_direction = '0;
                    state_next               = S_EMIT;
                    case (item.mode)
                        MODE_EXIT:
                        begin
                            exit_we = room_ok && dir_ok;
                        end
                        MODE_FLAG:
                        begin
                            nt_we = room_ok;
                        end
                        MODE_QUERY:
                        begin
                            if (!src_ok || !goal_ok)
                            begin
                                res_next.status = STATUS_ERROR;
                            end
                            else if (item.room == item.goal_room)
                            begin
                                res_next.status = STATUS_THERE;
                            end
                            else
                            begin
                                // Mark the source and scan its exits.
                                vis_we        = 1'b1;
                                base_next     = EXIT_AW'(32'(item.room[ROOM_W-1:0]) * NUM_DIRS);
                                dir_next      = '0;
                                src_mode_next = 1'b1;
                                goal_next     = item.goal_room;
                                head_next     = '0;
                                tail_next     = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_next.status = STATUS_ERROR;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue one exit read per cycle in direction order.
                a_vld_next   = 1'b1;
                a_first_next = src_mode_reg ? dir_reg : first_reg;
                if (dir_reg == DIR_W'(NUM_DIRS - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    dir_next = dir_reg + 1'b1;
                end
            end

            S_DRAIN:
            begin
                // Once the pipeline is empty, dequeue the next room or give up.
                if (!a_vld_reg && !b_vld_reg)
                begin
                    if (head_reg < tail_reg)
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        res_next.status          = STATUS_NOPATH;
                        res_next.first_direction = '0;
                        cnt_next                 = '0;
                        state_next               = S_CLEAR;
                    end
                end
            end

            S_POP:
            begin
                // Queue head is in the read register.
                base_next     = EXIT_AW'(32'(q_room) * NUM_DIRS);
                first_next    = q_dir;
                src_mode_next = 1'b0;
                head_next     = head_reg + 1'b1;
                dir_next      = '0;
                state_next    = S_SCAN;
            end

            S_CLEAR:
            begin
                // Sweep the visit marks back to zero.
                vis_we    = 1'b1;
                vis_waddr = cnt_reg[ROOM_W-1:0];
                vis_wdata = 1'b0;
                if (cnt_reg == EXIT_AW'(ROOMS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_EMIT:
            begin
                rsp.res_vld = 1'b1;
                if (req.res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Exit stage to flag stage.
        b_vld_next   = a_vld_reg && a_ok;
        b_to_next    = a_to;
        b_first_next = a_first_reg;

        // Flag stage: mark and enqueue a taken target.
        mark_vld_next  = b_take;
        mark_room_next = b_to_reg[ROOM_W-1:0];
        if (b_take)
        begin
            vis_we    = 1'b1;
            vis_waddr = b_to_reg[ROOM_W-1:0];
            vis_wdata = 1'b1;
            q_we      = 1'b1;
            tail_next = tail_reg + 1'b1;
            if (b_to_reg == goal_reg)
            begin
                // Goal reached: flush the pipeline and clear the marks.
                res_next.status          = STATUS_FOUND;
                res_next.first_direction = 3'(b_first_reg);
                a_vld_next               = 1'b0;
                b_vld_next               = 1'b0;
                cnt_next                 = '0;
                state_next               = S_CLEAR;
            end
        end
    end

    assign result = res_reg;

endmodule

FILE: hdl/bfs_first_step_finder_top.sv
// ----------------------------------------------------------------------------
// bfs_first_step_finder_top: first step on a shortest path in a room graph
// Loads exits and no-track flags and answers path queries with the first
// direction of a breadth-first shortest path.
//
//   Channel  Signals                          Beat
//   req      req_valid, req_ready, req_data   one write or query item
//   rsp      rsp_valid, rsp_ready, rsp_data   one status and direction
//   cfg      cfg_we, cfg_wdata                top_room register write
//
// Writes, invalid modes, out-of-range queries and already-there queries go
// straight to the result. A search scans the exits of the source, then those
// of each dequeued room, through the edge pipeline, then sweeps the visit
// marks. After reset a clearing pass runs over the exit table with req_ready
// low. One item is in work at a time; the output register holds a result
// while the next item is taken.
// ----------------------------------------------------------------------------
module bfs_first_step_finder_top
    import bfs_pkg::*;
#(
    parameter int MAX_ROOMS = 1024,
    parameter int NUM_DIRS  = 6
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  in_item_t                req_data,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output out_item_t               rsp_data,
    input  logic                    cfg_we,
    input  logic [ROOM_FIELD_W-1:0] cfg_wdata
);

    logic [ROOM_FIELD_W-1:0] top_room_reg;
    logic                    rsp_valid_reg, rsp_valid_next;
    out_item_t               rsp_data_reg;
    core_req_t               core_req;
    core_rsp_t               core_rsp;
    out_item_t               core_result;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_room_reg <= TOP_ROOM_RESET;
        end
        else if (cfg_we)
        begin
            top_room_reg <= cfg_wdata;
        end
    end

    // Handshake to the core.
    assign req_ready         = core_rsp.idle;
    assign core_req.start    = req_valid && core_rsp.idle;
    assign core_req.res_take = !rsp_valid_reg || rsp_ready;

    bfs_core #(
        .MAX_ROOMS (MAX_ROOMS),
        .NUM_DIRS  (NUM_DIRS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (req_data),
        .top_room (top_room_reg),
        .req      (core_req),
        .rsp      (core_rsp),
        .result   (core_result)
    );

    // Output register: loads a result when empty or being drained.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (core_rsp.res_vld && core_req.res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_rsp.res_vld && core_req.res_take)
        begin
            rsp_data_reg <= core_result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

FILE: dv/bfs_first_step_finder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfs_first_step_finder_top_tb: self-checking bench for the path finder
// Loads small room graphs through exit and no-track writes, queries paths
// under several top_room settings and compares every response beat with a
// breadth-first predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module bfs_first_step_finder_top_tb
    import bfs_pkg::*;
();

    localparam int MAX_ROOMS   = 1024;
    localparam int NUM_DIRS    = 6;
    localparam int POOL_ROOMS  = 12;
    localparam int STALL_LIMIT = 100000;
    localparam int SETTLE      = 8;
    localparam int TAIL_CYCLES = 2048;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_ready;
    in_item_t                req_data  = '0;
    logic                    rsp_valid;
    logic                    rsp_ready = 1'b0;
    out_item_t               rsp_data;
    logic                    cfg_we    = 1'b0;
    logic [ROOM_FIELD_W-1:0] cfg_wdata = '0;

    int burst_left;
    int rx_cycle;
    int rx_style;

    // Scoreboard: graph copy, breadth-first predictor and expected steps.
    class first_step_scoreboard;
        logic [EXIT_W-1:0] exit_table [MAX_ROOMS*NUM_DIRS];
        bit                no_track_room [MAX_ROOMS];
        int                top_room;
        out_item_t         expected_steps [$];
        int                errors;

        function new();
            foreach (exit_table[i])
                exit_table[i] = '0;
            foreach (no_track_room[i])
                no_track_room[i] = 1'b0;
            top_room = TOP_ROOM_RESET;
            errors   = 0;
        endfunction

        // Breadth-first search from src; returns the first hop toward goal.
        function out_item_t search_first_step(int src, int goal);
            out_item_t         r;
            bit                marks [MAX_ROOMS];
            int                q_room [$];
            int                q_dir [$];
            int                head;
            int                cur;
            int                first;
            int                to;
            bit                done;
            logic [EXIT_W-1:0] e;
            r.status          = STATUS_NOPATH;
            r.first_direction = '0;
            if (src > top_room || goal > top_room)
            begin
                r.status = STATUS_ERROR;
                return r;
            end
            if (src == goal)
            begin
                r.status = STATUS_THERE;
                return r;
            end
            foreach (marks[i])
                marks[i] = 1'b0;
            marks[src] = 1'b1;
            cur   = src;
            first = -1;
            head  = 0;
            done  = 1'b0;
            while (!done)
            begin
                // Expand the current room in direction order.
                for (int d = 0; d < NUM_DIRS; d++)
                begin
                    e  = exit_table[cur*NUM_DIRS + d];
                    to = e[ROOM_FIELD_W-1:0];
                    if (e[ROOM_FIELD_W] && to <= top_room && !no_track_room[to] && !marks[to])
                    begin
                        marks[to] = 1'b1;
                        q_room.push_back(to);
                        q_dir.push_back((first < 0) ? d : first);
                    end
                end
                // Dequeue the next room and test it against the goal.
                if (head >= q_room.size())
                    done = 1'b1;
                else
                begin
                    cur   = q_room[head];
                    first = q_dir[head];
                    head++;
                    if (cur == goal)
                    begin
                        r.status          = STATUS_FOUND;
                        r.first_direction = 3'(first);
                        done              = 1'b1;
                    end
                end
            end
            return r;
        endfunction

        // Applies one request beat to the graph copy and returns its response.
        function out_item_t predict_first_step(in_item_t it);
            out_item_t r;
            r.status          = STATUS_WRITE;
            r.first_direction = '0;
            case (it.mode)
                MODE_EXIT:
                    if (it.direction < NUM_DIRS)
                        exit_table[int'(it.room)*NUM_DIRS + int'(it.direction)] =
                            it.exit_present ? {1'b1, it.exit_target} : '0;
                MODE_FLAG:
                    no_track_room[it.room] = it.no_track;
                MODE_QUERY:
                    r = search_first_step(int'(it.room), int'(it.goal_room));
                default:
                    r.status = STATUS_ERROR;
            endcase
            return r;
        endfunction

        function void note_item(in_item_t it);
            expected_steps.push_back(predict_first_step(it));
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_step(out_item_t got);
            out_item_t want;
            if (expected_steps.size() == 0)
            begin
                report($sformatf("response beat with nothing expected: status %0d dir %0d",
                                 got.status, got.first_direction));
                return;
            end
            want = expected_steps.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.first_direction !== want.first_direction)
                report($sformatf("first_direction %0d, expected %0d",
                                 got.first_direction, want.first_direction));
        endtask
    endclass

    first_step_scoreboard sb = new();

    bfs_first_step_finder_top #(
        .MAX_ROOMS (MAX_ROOMS),
        .NUM_DIRS  (NUM_DIRS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver back-pressure in one of three styles, redrawn at random.
    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_style = $urandom_range(0, 2);
        case (rx_style)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ((rx_cycle % 16) >= 5);
        endcase
    end

    // Monitor: note accepted request beats and check response beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_item(req_data);
            if (rsp_valid && rsp_ready)
                sb.check_step(rsp_data);
        end
    end

    // Watchdog on cycles without any accepted beat.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Room choice: mostly a small pool, sometimes near top_room, sometimes anywhere.
    function automatic logic [ROOM_FIELD_W-1:0] pick_room();
        int roll;
        int hi;
        int lo;
        roll = $urandom_range(0, 19);
        hi   = sb.top_room;
        lo   = (hi > 3) ? hi - 3 : 0;
        if (roll < 16)
            return ROOM_FIELD_W'($urandom_range(0, POOL_ROOMS - 1));
        else if (roll < 18)
            return ROOM_FIELD_W'($urandom_range(lo, hi));
        return ROOM_FIELD_W'($urandom_range(0, FIELD_ROOMS - 1));
    endfunction

    // Fully random payload; the builders below override the fields that matter.
    function automatic in_item_t random_payload();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    function automatic in_item_t exit_beat(int room, int dir, bit present, int target);
        in_item_t it;
        it              = random_payload();
        it.mode         = MODE_EXIT;
        it.room         = ROOM_FIELD_W'(room);
        it.direction    = 3'(dir);
        it.exit_present = present;
        it.exit_target  = ROOM_FIELD_W'(target);
        return it;
    endfunction

    function automatic in_item_t flag_beat(int room, bit nt);
        in_item_t it;
        it          = random_payload();
        it.mode     = MODE_FLAG;
        it.room     = ROOM_FIELD_W'(room);
        it.no_track = nt;
        return it;
    endfunction

    function automatic in_item_t query_beat(int src, int goal);
        in_item_t it;
        it           = random_payload();
        it.mode      = MODE_QUERY;
        it.room      = ROOM_FIELD_W'(src);
        it.goal_room = ROOM_FIELD_W'(goal);
        return it;
    endfunction

    // Random request mix: mostly graph building and queries, some noise.
    function automatic in_item_t random_item();
        in_item_t it;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 48)
            it = exit_beat(pick_room(),
                           (roll < 3) ? $urandom_range(6, 7) : $urandom_range(0, NUM_DIRS - 1),
                           ($urandom_range(0, 6) != 0), pick_room());
        else if (roll < 58)
            it = flag_beat(pick_room(), ($urandom_range(0, 2) == 0));
        else if (roll < 94)
            it = query_beat(pick_room(), pick_room());
        else
        begin
            it      = random_payload();
            it.mode = MODE_UNUSED;
        end
        return it;
    endfunction

    // Sends one request beat; valid stays high inside a burst, drops between bursts.
    task automatic send_item(in_item_t it);
        req_data  <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // Stops sending and waits until every expected response has arrived.
    task automatic drain_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_top_room(int value);
        cfg_wdata <= ROOM_FIELD_W'(value);
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we      <= 1'b0;
        sb.top_room  = value;
    endtask

    // Main sequence.
    initial
    begin
        in_item_t odd_item;
        int       phase_tops [6];
        phase_tops    = '{11, 0, 1023, 5, 0, 1023};
        phase_tops[4] = $urandom_range(1, 1022);
        rx_cycle      = 0;
        rx_style      = 0;
        burst_left    = $urandom_range(1, 8);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_top_room(TOP_ROOM_RESET);

        // Directed: empty graph, then a small graph with ordering checks.
        send_item(query_beat(5, 5));
        send_item(query_beat(0, 1));
        send_item(exit_beat(0, 0, 1'b1, 1));
        send_item(exit_beat(0, 1, 1'b1, 2));
        send_item(exit_beat(1, 2, 1'b1, 3));
        send_item(exit_beat(2, 5, 1'b1, 3));
        send_item(query_beat(0, 3));
        send_item(exit_beat(0, 5, 1'b1, 1023));
        send_item(query_beat(0, 1023));
        // No-track goal, no-track source and source equal to goal.
        send_item(flag_beat(1, 1'b1));
        send_item(query_beat(0, 3));
        send_item(query_beat(0, 1));
        send_item(flag_beat(0, 1'b1));
        send_item(query_beat(0, 2));
        send_item(query_beat(0, 0));
        // Exit writes with a direction beyond the last one are dropped.
        send_item(exit_beat(3, 6, 1'b1, 0));
        send_item(exit_beat(3, 7, 1'b1, 0));
        send_item(query_beat(3, 0));
        // Clearing an exit, the unused mode, and the highest room as source.
        send_item(exit_beat(0, 5, 1'b0, 1023));
        send_item(query_beat(0, 1023));
        odd_item      = random_payload();
        odd_item.mode = MODE_UNUSED;
        send_item(odd_item);
        send_item(query_beat(1023, 0));
        send_item(flag_beat(0, 1'b0));
        send_item(flag_beat(1, 1'b0));

        // Directed with a tiny top room: rooms and exits above it.
        drain_idle();
        set_top_room(2);
        send_item(query_beat(0, 3));
        send_item(query_beat(3, 0));
        send_item(query_beat(0, 2));
        send_item(query_beat(1, 2));

        // Random phases, each under its own top_room setting.
        foreach (phase_tops[p])
        begin
            drain_idle();
            set_top_room(phase_tops[p]);
            repeat (12) send_item(random_item());
        end

        drain_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected responses never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: bfs_first_step_finder_top.f
hdl/bfs_pkg.sv
hdl/bfs_core.sv
hdl/bfs_first_step_finder_top.sv
dv/bfs_first_step_finder_top_tb.sv
